// ===== sv/osd_char_screen_writer_top_defines.svh =====
// ----------------------------------------------------------------------------
// OSD character screen writer assertion macros
// Shared concurrent assertion forms used by the screen writer top level.
// ----------------------------------------------------------------------------
`ifndef OSD_CHAR_SCREEN_WRITER_TOP_DEFINES_SVH
`define OSD_CHAR_SCREEN_WRITER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OCSW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OCSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ocsw_pkg.sv =====
// ----------------------------------------------------------------------------
// OSD character screen writer package
// Codes, field widths and the parser-to-memory command type.
// ----------------------------------------------------------------------------
`default_nettype none

package ocsw_pkg;

    localparam int CODE_W = 9;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_DISC = 2'd2;

    // Sub-commands seen while waiting for a sub-command.
    localparam logic [7:0] SUB_CLEAR  = 8'h02;
    localparam logic [7:0] SUB_STRING = 8'h03;

    // Info byte layout.
    localparam int INFO_EXT_BIT = 7;

    // Parser phases.
    localparam logic [2:0] PH_SUBCMD = 3'd0;
    localparam logic [2:0] PH_ROW    = 3'd1;
    localparam logic [2:0] PH_COL    = 3'd2;
    localparam logic [2:0] PH_INFO   = 3'd3;
    localparam logic [2:0] PH_CHARS  = 3'd4;

    // Command from the parser to the screen memory.
    typedef struct packed {
        logic              wr_en;
        logic              clr_start;
        logic [CODE_W-1:0] wr_code;
    } t_ps_cmd;

endpackage

`default_nettype wire

// ===== sv/ocsw_if.sv =====
// ----------------------------------------------------------------------------
// OSD character screen writer channel interfaces
// Valid/ready channels for command items in and character codes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocsw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] read_row;
    logic [7:0] read_col;

    modport source (output valid, output kind, output data_byte, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input kind, input data_byte, input read_row,
                    input read_col, output ready);
endinterface

interface ocsw_out_if;
    logic                         valid;
    logic                         ready;
    logic [ocsw_pkg::CODE_W-1:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== sv/osd_char_screen_writer_top.sv =====
// A read item's character code passes through the memory read register, then the
//   output register, before it is offered on the output.
// Throughput: one item per cycle outside the clearing sweep; a read waits only while
//   the previous code is stalled. A clear sub-command holds the input off during its sweep.
// Reset (synchronous, active low) starts the same clearing sweep, so the input is
//   not ready until that sweep has cleared every cell after reset is released.
// ----------------------------------------------------------------------------
// OSD character screen writer
// Parses on-screen-display command bytes into a character screen held in a
// synchronous memory and answers read items with the stored 9-bit code.
// ----------------------------------------------------------------------------
`default_nettype none
`include "osd_char_screen_writer_top_defines.svh"

module osd_char_screen_writer_top #(
    parameter int SCREEN_ROW_COUNT = 22,
    parameter int SCREEN_COL_COUNT = 60
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ocsw_in_if.sink     i_in,
    ocsw_out_if.source  o_out
);

    // The screen is stored row-major: cell address = row * columns + column.
    localparam int CELLS = SCREEN_ROW_COUNT * SCREEN_COL_COUNT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    ocsw_pkg::t_ps_cmd              w_cmd;
    logic [AW-1:0]                  w_wr_addr;
    logic                           w_clearing;
    logic [ocsw_pkg::CODE_W-1:0]    w_mem_q;

    logic        w_acc;
    logic        w_byte_en;
    logic        w_disc;
    logic        w_rd_en;
    logic        w_rd_ok;
    logic [15:0] w_rd_lin;
    logic [AW-1:0] w_rd_addr;
    logic        w_move;
    logic        w_pend_hold;

    // A read beat leaves its data in the memory read register (flagged by r_rd_pend) and
    // moves to the output register once that register is free or being taken.
    logic                        r_rd_pend,   n_rd_pend;
    logic                        r_rd_ok;
    logic                        r_out_valid, n_out_valid;
    logic [ocsw_pkg::CODE_W-1:0] r_out_code;

    assign w_move = r_rd_pend && (!r_out_valid || o_out.ready);

    // Input beats are held off during the clearing sweep. Command bytes and
    // disconnects never wait on the output; a read waits only while an earlier
    // read's data still sits in the memory read register and cannot move on.
    assign i_in.ready = !w_clearing
                        && ((i_in.kind != ocsw_pkg::KIND_READ) || !r_rd_pend || w_move);

    assign w_acc     = i_in.valid && i_in.ready;
    assign w_byte_en = w_acc && (i_in.kind == ocsw_pkg::KIND_BYTE);
    assign w_disc    = w_acc && (i_in.kind == ocsw_pkg::KIND_DISC);
    assign w_rd_en   = w_acc && (i_in.kind == ocsw_pkg::KIND_READ);

    // Off-screen reads still read the memory (at cell zero) but answer zero.
    assign w_rd_ok   = (i_in.read_row < 8'(SCREEN_ROW_COUNT))
                       && (i_in.read_col < 8'(SCREEN_COL_COUNT));
    assign w_rd_lin  = 16'(i_in.read_row) * 16'(SCREEN_COL_COUNT) + 16'(i_in.read_col);
    assign w_rd_addr = w_rd_ok ? AW'(w_rd_lin) : '0;

    // Pending read data that neither moves on nor is replaced this cycle.
    assign w_pend_hold = r_rd_pend && !w_move && !w_rd_en;

    ocsw_parser #(
        .SCREEN_ROW_COUNT (SCREEN_ROW_COUNT),
        .SCREEN_COL_COUNT (SCREEN_COL_COUNT),
        .AW               (AW)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_byte_en),
        .i_disc    (w_disc),
        .i_byte    (i_in.data_byte),
        .o_cmd     (w_cmd),
        .o_wr_addr (w_wr_addr)
    );

    // A character write and a read never share a cycle: at most one beat is
    // accepted per cycle, and a write lands before any later read samples it.
    ocsw_screen_mem #(
        .SCREEN_ROW_COUNT (SCREEN_ROW_COUNT),
        .SCREEN_COL_COUNT (SCREEN_COL_COUNT),
        .AW               (AW)
    ) u_screen_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_wr_addr  (w_wr_addr),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_mem_q),
        .o_clearing (w_clearing)
    );

    always_comb begin
        n_rd_pend = r_rd_pend;
        if (w_rd_en) begin
            n_rd_pend = 1'b1;
        end else if (w_move) begin
            n_rd_pend = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_ok <= w_rd_ok;
        end
        if (w_move) begin
            r_out_code <= r_rd_ok ? w_mem_q : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_code;

    // An accepted read always leaves its data waiting in the read register.
    `OCSW_ASSERT_NEXT(a_read_pends, i_clk, i_rst_n, w_rd_en, r_rd_pend, "read beat lost")

    // Read data that cannot move on is held, never dropped.
    `OCSW_ASSERT_NEXT(a_pend_holds, i_clk, i_rst_n, w_pend_hold, r_rd_pend, "pending read dropped")

    // A clear sub-command starts the sweep on the next cycle.
    `OCSW_ASSERT_NEXT(a_clear_starts, i_clk, i_rst_n, w_cmd.clr_start, w_clearing, "no clear sweep")

    // The parser never writes a character while the sweep owns the memory.
    `OCSW_ASSERT_SAME(a_no_wr_clr, i_clk, i_rst_n, w_clearing, !w_cmd.wr_en, "write during clear")

endmodule

`default_nettype wire

// ===== sv/ocsw_parser.sv =====
// ----------------------------------------------------------------------------
// OSD command parser
// Walks the sub-command, row, column, info and character bytes of a string
// and turns each on-screen character into a memory write and a clear into a sweep start.
// ----------------------------------------------------------------------------
`default_nettype none

module ocsw_parser #(
    parameter int SCREEN_ROW_COUNT = 22,
    parameter int SCREEN_COL_COUNT = 60,
    parameter int AW               = 11
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_byte_en,
    input  wire logic                i_disc,
    input  wire logic [7:0]          i_byte,
    output ocsw_pkg::t_ps_cmd        o_cmd,
    output logic      [AW-1:0]       o_wr_addr
);

    localparam int SW = ((AW > 9) ? AW : 9) + 1;

    logic [2:0]    r_phase,    n_phase;
    logic          r_row_ok,   n_row_ok;
    logic [AW-1:0] r_row_base, n_row_base;
    logic [7:0]    r_col,      n_col;
    logic [6:0]    r_len,      n_len;
    logic [6:0]    r_pos,      n_pos;
    logic          r_ext,      n_ext;

    logic [8:0]    w_col_sum;
    logic          w_col_ok;
    logic [15:0]   w_row_prod;
    logic [6:0]    w_pos_inc;

    assign w_col_sum  = {1'b0, r_col} + {2'b00, r_pos};
    assign w_col_ok   = (w_col_sum < 9'(SCREEN_COL_COUNT));
    assign w_row_prod = 16'(i_byte) * 16'(SCREEN_COL_COUNT);
    assign w_pos_inc  = r_pos + 7'd1;

    assign o_cmd.wr_en     = i_byte_en && (r_phase == ocsw_pkg::PH_CHARS)
                             && r_row_ok && w_col_ok;
    assign o_cmd.clr_start = i_byte_en && (r_phase == ocsw_pkg::PH_SUBCMD)
                             && (i_byte == ocsw_pkg::SUB_CLEAR);
    assign o_cmd.wr_code   = {r_ext, i_byte};
    assign o_wr_addr       = AW'(SW'(r_row_base) + SW'(w_col_sum));

    always_comb begin
        n_phase    = r_phase;
        n_row_ok   = r_row_ok;
        n_row_base = r_row_base;
        n_col      = r_col;
        n_len      = r_len;
        n_pos      = r_pos;
        n_ext      = r_ext;
        if (i_disc) begin
            n_phase = ocsw_pkg::PH_SUBCMD;
        end else if (i_byte_en) begin
            unique case (r_phase)
                ocsw_pkg::PH_SUBCMD: begin
                    if (i_byte == ocsw_pkg::SUB_STRING) begin
                        n_row_ok   = 1'b0;
                        n_row_base = '0;
                        n_col      = '0;
                        n_len      = '0;
                        n_pos      = '0;
                        n_ext      = 1'b0;
                        n_phase    = ocsw_pkg::PH_ROW;
                    end
                end
                ocsw_pkg::PH_ROW: begin
                    // Only an on-screen row gets a base; off-screen rows never write.
                    n_row_ok   = (i_byte < 8'(SCREEN_ROW_COUNT));
                    n_row_base = n_row_ok ? AW'(w_row_prod) : '0;
                    n_phase    = ocsw_pkg::PH_COL;
                end
                ocsw_pkg::PH_COL: begin
                    n_col   = i_byte;
                    n_phase = ocsw_pkg::PH_INFO;
                end
                ocsw_pkg::PH_INFO: begin
                    n_ext   = i_byte[ocsw_pkg::INFO_EXT_BIT];
                    n_len   = i_byte[6:0];
                    n_pos   = '0;
                    n_phase = (i_byte[6:0] == 7'd0) ? ocsw_pkg::PH_SUBCMD
                                                    : ocsw_pkg::PH_CHARS;
                end
                ocsw_pkg::PH_CHARS: begin
                    n_pos = w_pos_inc;
                    if (w_pos_inc == r_len) begin
                        n_phase = ocsw_pkg::PH_SUBCMD;
                    end
                end
                default: begin
                    n_phase = ocsw_pkg::PH_SUBCMD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ocsw_pkg::PH_SUBCMD;
            r_row_ok   <= 1'b0;
            r_row_base <= '0;
            r_col      <= '0;
            r_len      <= '0;
            r_pos      <= '0;
            r_ext      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_row_ok   <= n_row_ok;
            r_row_base <= n_row_base;
            r_col      <= n_col;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_ext      <= n_ext;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ocsw_screen_mem.sv =====
// ----------------------------------------------------------------------------
// OSD screen memory
// One-write, one-read synchronous store of character codes with a clearing
// sweep that zeroes one cell per cycle after reset and on a clear command.
// ----------------------------------------------------------------------------
`default_nettype none

module ocsw_screen_mem #(
    parameter int SCREEN_ROW_COUNT = 22,
    parameter int SCREEN_COL_COUNT = 60,
    parameter int AW               = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  ocsw_pkg::t_ps_cmd                  i_cmd,
    input  wire logic [AW-1:0]                 i_wr_addr,
    input  wire logic                          i_rd_en,
    input  wire logic [AW-1:0]                 i_rd_addr,
    output logic      [ocsw_pkg::CODE_W-1:0]   o_rd_data,
    output logic                               o_clearing
);

    localparam int CELLS = SCREEN_ROW_COUNT * SCREEN_COL_COUNT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    logic [ocsw_pkg::CODE_W-1:0] r_screen [CELLS];
    logic [ocsw_pkg::CODE_W-1:0] r_rd_data;

    logic          r_clearing, n_clearing;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic                        w_we;
    logic [AW-1:0]               w_addr;
    logic [ocsw_pkg::CODE_W-1:0] w_data;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (i_cmd.clr_start) begin
            n_clearing = 1'b1;
            n_clr_addr = '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign w_we   = r_clearing || i_cmd.wr_en;
    assign w_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_data = r_clearing ? '0 : i_cmd.wr_code;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_screen[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_screen[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire
